[design/rtz_pkg.sv]
// ----------------------------------------------------------------------------
// rtz_pkg: shared types and constants of the rotozoom texel sampler
// Texture geometry, datapath widths, operation codes and register indexes.
// ----------------------------------------------------------------------------
package rtz_pkg;

    // Texture geometry, kept as powers of two so that wrapping is a mask.
    localparam int unsigned TEX_W_LOG2  = 7;
    localparam int unsigned TEX_H_LOG2  = 7;
    localparam int unsigned TEX_WIDTH   = 1 << TEX_W_LOG2;
    localparam int unsigned TEX_HEIGHT  = 1 << TEX_H_LOG2;
    localparam int unsigned STORE_AW    = TEX_W_LOG2 + TEX_H_LOG2;
    localparam int unsigned STORE_DEPTH = TEX_WIDTH * TEX_HEIGHT;

    // Field widths.
    localparam int unsigned IDX_W    = 14;
    localparam int unsigned COLOR_W  = 8;
    localparam int unsigned SCREEN_W = 8;
    localparam int unsigned COEF_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Datapath widths: centered column and row, products and sums.
    localparam int unsigned PX_W      = SCREEN_W + 1;
    localparam int unsigned PY_W      = SCREEN_W + 2;
    localparam int unsigned PROD_W    = COEF_W + PY_W;
    localparam int unsigned SUM_W     = PROD_W + 1;
    localparam int unsigned FRAC_BITS = 12;

    // Register reset values.
    localparam logic signed [COEF_W-1:0] SINE_RESET   = 16'sd0;
    localparam logic signed [COEF_W-1:0] COSINE_RESET = 16'sd4096;
    localparam logic [SCREEN_W-1:0]      WIDTH_RESET  = 8'd80;
    localparam logic [SCREEN_W-1:0]      HEIGHT_RESET = 8'd24;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SINE   = 2'd0,
        CFG_COSINE = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

endpackage

[design/rtz_ram.sv]
// ----------------------------------------------------------------------------
// rtz_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rtz_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/rotozoom_texel_sampler_core.sv]
// ----------------------------------------------------------------------------
// rotozoom_texel_sampler_core: rotozoom texture sampler, one word per cycle unless stalled
// Loads palette colors into a texture store and samples it along a rotated,
// scaled grid of screen cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): each word is either a load
//   (i_operation = load) that writes i_texel_color at i_texel_index, or a
//   sample (i_operation = sample) of cell i_screen_col / i_screen_row.
//   Output channel (o_valid / i_stall): one word per sample, carrying the
//   texel color and a draw flag that is set for a nonzero color. Loads give
//   no output word.
//   Configuration: write sine, cosine, screen width and height through
//   i_cfg_we / i_cfg_index / i_cfg_data while no word is in flight.
//   Throughput: one word per cycle while o_stall is low. A word reaches
//   o_valid through five register stages (center, multiply, sum,
//   address, store read).
//   Every word passes the texture store at the address stage, loads through
//   the write port and samples through the read port, in arrival order, so a
//   sample always sees every earlier load.
//   Reset: empties the pipeline and restores default coefficients and screen
//   size. The texture store is not cleared; load texels before sampling them.
//   Stall: a stalled output word holds; the stages behind it keep filling,
//   and o_stall rises only once every stage holds a word.
// ----------------------------------------------------------------------------
module rotozoom_texel_sampler_core
    import rtz_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [COEF_W-1:0]             i_cfg_data,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [IDX_W-1:0]              i_texel_index,
    input  logic [COLOR_W-1:0]            i_texel_color,
    input  logic [SCREEN_W-1:0]           i_screen_col,
    input  logic [SCREEN_W-1:0]           i_screen_row,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [COLOR_W-1:0]            o_color,
    output logic                          o_draw
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COEF_W-1:0] r_sine;
    logic signed [COEF_W-1:0] r_cosine;
    logic [SCREEN_W-1:0]      r_width;
    logic [SCREEN_W-1:0]      r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sine   <= SINE_RESET;
            r_cosine <= COSINE_RESET;
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SINE:   r_sine   <= i_cfg_data;
                CFG_COSINE: r_cosine <= i_cfg_data;
                CFG_WIDTH:  r_width  <= i_cfg_data[SCREEN_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[SCREEN_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-stage ready chain: a stage advances when it is empty or the stage
    // after it advances, so bubbles are squeezed out under stall.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    t_op  r_op1, r_op2, r_op3, r_op4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    assign w_rdy5 = !r_v5 || !i_stall;
    // a load leaves at the address stage, never waiting on the output
    assign w_rdy4 = !r_v4 || (r_op4 == OP_LOAD) || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;

    // ------------------------------------------------------------------
    // Stage 1: center the cell, halving the column for character aspect
    // ------------------------------------------------------------------
    logic signed [PX_W-1:0]  n_px;
    logic signed [PY_W-1:0]  n_py;
    logic signed [PX_W-1:0]  r_px;
    logic signed [PY_W-1:0]  r_py;
    logic [IDX_W-1:0]        r_idx1, r_idx2, r_idx3, r_idx4;
    logic [COLOR_W-1:0]      r_col1, r_col2, r_col3, r_col4;

    assign n_px = $signed({2'b00, i_screen_col[SCREEN_W-1:1]})
                - $signed({3'b000, r_width[SCREEN_W-1:2]});
    assign n_py = $signed({2'b00, i_screen_row})
                - $signed({3'b000, r_height[SCREEN_W-1:1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_op1  <= t_op'(i_operation);
            r_idx1 <= i_texel_index;
            r_col1 <= i_texel_color;
            r_px   <= n_px;
            r_py   <= n_py;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the four rotation products
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_sin_px, r_cos_py, r_sin_py, r_cos_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_op2    <= r_op1;
            r_idx2   <= r_idx1;
            r_col2   <= r_col1;
            r_sin_px <= PROD_W'(r_sine)   * PROD_W'(r_px);
            r_cos_py <= PROD_W'(r_cosine) * PROD_W'(r_py);
            r_sin_py <= PROD_W'(r_sine)   * PROD_W'(r_py);
            r_cos_px <= PROD_W'(r_cosine) * PROD_W'(r_px);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: rotated coordinates in Q.12
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] r_sx, r_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_op3  <= r_op2;
            r_idx3 <= r_idx2;
            r_col3 <= r_col2;
            r_sx   <= SUM_W'(r_sin_px) + SUM_W'(r_cos_py);
            r_sy   <= SUM_W'(r_sin_py) - SUM_W'(r_cos_px);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitude, drop the fraction, wrap to the texture
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]      n_mag_x, n_mag_y;
    logic [STORE_AW-1:0]   n_addr;
    logic [STORE_AW-1:0]   r_addr4;

    assign n_mag_x = r_sx[SUM_W-1] ? SUM_W'(-r_sx) : SUM_W'(r_sx);
    assign n_mag_y = r_sy[SUM_W-1] ? SUM_W'(-r_sy) : SUM_W'(r_sy);
    assign n_addr  = {n_mag_y[FRAC_BITS +: TEX_H_LOG2], n_mag_x[FRAC_BITS +: TEX_W_LOG2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_op4   <= r_op3;
            r_idx4  <= r_idx3;
            r_col4  <= r_col3;
            r_addr4 <= n_addr;
        end
    end

    // ------------------------------------------------------------------
    // Texture store: loads write and samples read from the same stage, so
    // the store sees every word in arrival order.
    // ------------------------------------------------------------------
    logic                w_ram_we, w_ram_re, w_load_ok;
    logic [COLOR_W-1:0]  w_ram_q;

    // ignore loads past the end of the store
    assign w_load_ok = 32'(r_idx4) < STORE_DEPTH;
    assign w_ram_we  = r_v4 && (r_op4 == OP_LOAD) && w_load_ok;
    assign w_ram_re  = r_v4 && (r_op4 == OP_SAMPLE) && w_rdy5;

    rtz_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (STORE_DEPTH)
    ) u_tex_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx4[STORE_AW-1:0]),
        .i_wdata (r_col4),
        .i_re    (w_ram_re),
        .i_raddr (r_addr4),
        .o_rdata (w_ram_q)
    );

    // ------------------------------------------------------------------
    // Stage 5: output word; the RAM read register holds the color
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_rdy5) begin
            r_v5 <= r_v4 && (r_op4 == OP_SAMPLE);
        end
    end

    assign o_valid = r_v5;
    assign o_color = w_ram_q;
    assign o_draw  = |w_ram_q;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_load_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && (r_op4 == OP_LOAD) && w_rdy5) |=> !r_v5)
        else $error("load produced an output word");

    a_sample_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && (r_op4 == OP_SAMPLE) && w_rdy5) |=> r_v5)
        else $error("sample lost before the output stage");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_stall))
        else $error("input stalled while a stage is empty");

    a_sum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !w_rdy4) |=> (r_v3 && $stable(r_sx) && $stable(r_sy)))
        else $error("stage 3 changed while blocked");

endmodule

[tb/rotozoom_texel_sampler_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotozoom_texel_sampler_core_tb: self-checking bench of the texel sampler
// Loads texels and samples screen cells under several coefficient and screen
// settings and under random idling and stalling on both channels. A local
// predictor tracks the texture and the frame settings and works out each
// output word, which is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module rotozoom_texel_sampler_core_tb;
    import rtz_pkg::*;

    // Cycles to let a trailing load clear the five-stage pipeline.
    localparam int unsigned SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               draw;
    } t_texel_word;

    // Block inputs, all known from time zero.
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    t_cfg_idx              i_cfg_index   = CFG_SINE;
    logic [COEF_W-1:0]     i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    t_op                   i_operation   = OP_LOAD;
    logic [IDX_W-1:0]      i_texel_index = '0;
    logic [COLOR_W-1:0]    i_texel_color = '0;
    logic [SCREEN_W-1:0]   i_screen_col  = '0;
    logic [SCREEN_W-1:0]   i_screen_row  = '0;
    logic                  i_stall       = 1'b0;

    logic                  o_stall;
    logic                  o_valid;
    logic [COLOR_W-1:0]    o_color;
    logic                  o_draw;

    // Predictor state: frame settings and the texture as loaded so far.
    logic signed [COEF_W-1:0] frame_sine   = SINE_RESET;
    logic signed [COEF_W-1:0] frame_cosine = COSINE_RESET;
    logic [SCREEN_W-1:0]      frame_width  = WIDTH_RESET;
    logic [SCREEN_W-1:0]      frame_height = HEIGHT_RESET;
    logic [COLOR_W-1:0]       texture_shadow [STORE_DEPTH];
    bit                       texel_known    [STORE_DEPTH];

    // Output words still owed by the block, oldest first.
    t_texel_word texels_due [$];

    int fault_count   = 0;
    int words_sent    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;

    rotozoom_texel_sampler_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_texel_index (i_texel_index),
        .i_texel_color (i_texel_color),
        .i_screen_col  (i_screen_col),
        .i_screen_row  (i_screen_row),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_color       (o_color),
        .o_draw        (o_draw)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Store address that a screen cell maps to under the current frame:
    // center the cell (column halved), rotate and scale in Q4.12, truncate
    // toward zero, fold negatives to their magnitude, wrap to the texture.
    function automatic int unsigned cell_address(input logic [SCREEN_W-1:0] col,
                                                 input logic [SCREEN_W-1:0] row);
        longint          px;
        longint          py;
        longint          sx;
        longint          sy;
        longint unsigned u;
        longint unsigned v;
        px = longint'(col >> 1) - longint'(frame_width >> 2);
        py = longint'(row) - longint'(frame_height >> 1);
        sx = longint'(frame_sine) * px + longint'(frame_cosine) * py;
        sy = longint'(frame_sine) * py - longint'(frame_cosine) * px;
        u  = ((sx < 0) ? -sx : sx) >> FRAC_BITS;
        v  = ((sy < 0) ? -sy : sy) >> FRAC_BITS;
        return (u % TEX_WIDTH) + (v % TEX_HEIGHT) * TEX_WIDTH;
    endfunction

    // Coefficient for a random frame, with the extremes and unity mixed in.
    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh1000;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Receiver: hold off for a counted stretch on request, else stall at random.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Check every accepted output word against the oldest owed one.
    always @(posedge i_clk) begin : check_output
        t_texel_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (texels_due.size() == 0) begin
                $display("%0t: output word with none owed: expected none, actual color %0h draw %0b",
                         $time, o_color, o_draw);
                fault_count++;
            end else begin
                want = texels_due.pop_front();
                if (o_color !== want.color) begin
                    $display("%0t: color mismatch: expected %0h, actual %0h",
                             $time, want.color, o_color);
                    fault_count++;
                end
                if (o_draw !== want.draw) begin
                    $display("%0t: draw mismatch: expected %0b, actual %0b",
                             $time, want.draw, o_draw);
                    fault_count++;
                end
            end
        end
    end

    // Offer one word after a random idle gap, hold it until accepted, and
    // advance the predictor at the accepting edge.
    task automatic send_word(input t_op                 op,
                             input logic [IDX_W-1:0]    idx,
                             input logic [COLOR_W-1:0]  color,
                             input logic [SCREEN_W-1:0] col,
                             input logic [SCREEN_W-1:0] row);
        int          gap;
        int unsigned addr;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_texel_index <= idx;
        i_texel_color <= color;
        i_screen_col  <= col;
        i_screen_row  <= row;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        words_sent++;
        if (op == OP_LOAD) begin
            // drop loads past the end of the store
            if (idx < STORE_DEPTH) begin
                texture_shadow[idx] = color;
                texel_known[idx]    = 1'b1;
            end
        end else begin
            addr = cell_address(col, row);
            texels_due.push_back('{texture_shadow[addr], texture_shadow[addr] != '0});
        end
    endtask

    // Sample a cell, loading its texel first if it was never written.
    task automatic sample_cell(input logic [SCREEN_W-1:0] col,
                               input logic [SCREEN_W-1:0] row);
        int unsigned addr;
        addr = cell_address(col, row);
        if (!texel_known[addr]) begin
            send_word(OP_LOAD, IDX_W'(addr),
                      ($urandom_range(3) == 0) ? 8'h00 : COLOR_W'($urandom), col, row);
        end
        send_word(OP_SAMPLE, IDX_W'($urandom), COLOR_W'($urandom), col, row);
    endtask

    // Drop valid and wait until every owed word is back and the pipe is empty.
    task automatic settle_pipeline();
        i_valid <= 1'b0;
        while (texels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive edges; only call when idle.
    task automatic program_frame(input logic signed [COEF_W-1:0] sine,
                                 input logic signed [COEF_W-1:0] cosine,
                                 input logic [SCREEN_W-1:0]      cols,
                                 input logic [SCREEN_W-1:0]      rows);
        t_cfg_idx          reg_order [4];
        logic [COEF_W-1:0] reg_value [4];
        int                k;
        reg_order = '{CFG_SINE, CFG_COSINE, CFG_WIDTH, CFG_HEIGHT};
        // screen size lives in the low byte; the upper byte is noise
        reg_value = '{sine, cosine, {8'($urandom), cols}, {8'($urandom), rows}};
        for (k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= reg_order[k];
            i_cfg_data  <= reg_value[k];
            @(posedge i_clk);
        end
        i_cfg_we     <= 1'b0;
        frame_sine   = sine;
        frame_cosine = cosine;
        frame_width  = cols;
        frame_height = rows;
    endtask

    // Reset settings: index and color extremes, center, corners, off-screen.
    task automatic test_reset_defaults();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_word(OP_LOAD, '0, 8'hFF, 8'd0, 8'd0);
        send_word(OP_LOAD, '1, 8'h00, 8'hFF, 8'hFF);
        sample_cell(8'd40, 8'd12);
        sample_cell(8'd0, 8'd0);
        sample_cell(8'd254, 8'd254);
    endtask

    // Coefficient and screen-size extremes, zero screen size included.
    task automatic test_frame_extremes();
        settle_pipeline();
        // zero screen size: this cell lands on the last texel
        program_frame(16'sh0000, 16'sh1000, 8'd0, 8'd0);
        sample_cell(8'd254, 8'd127);
        sample_cell(8'd0, 8'd0);
        settle_pipeline();
        program_frame(16'sh8000, 16'sh7FFF, 8'd255, 8'd255);
        sample_cell(8'd0, 8'd0);
        sample_cell(8'd254, 8'd254);
        settle_pipeline();
        program_frame(16'sh7FFF, 16'sh8000, 8'd1, 8'd1);
        sample_cell(8'd0, 8'd254);
        sample_cell(8'd254, 8'd0);
        settle_pipeline();
        program_frame(16'shFFFF, 16'sh0000, 8'd80, 8'd24);
        sample_cell(8'd40, 8'd12);
        sample_cell(8'd200, 8'd3);
    endtask

    // Random cells and stray loads over three random frames per idling mix.
    task automatic test_random_frames(input int idle_pct, input int hold_pct,
                                      input int word_goal);
        int stop_at;
        int seg;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        for (seg = 0; seg < 3; seg++) begin
            settle_pipeline();
            program_frame(pick_coef(), pick_coef(),
                          SCREEN_W'($urandom_range(255, 1)), SCREEN_W'($urandom_range(255, 1)));
            stop_at = words_sent + word_goal / 3;
            while (words_sent < stop_at) begin
                if ($urandom_range(99) < 80) begin
                    sample_cell(SCREEN_W'($urandom_range(254)), SCREEN_W'($urandom_range(254)));
                end else begin
                    send_word(OP_LOAD, IDX_W'($urandom), COLOR_W'($urandom),
                              SCREEN_W'($urandom), SCREEN_W'($urandom));
                end
            end
        end
    endtask

    // Long receiver hold-off while the sender keeps pushing, so the pipe fills
    // and o_stall rises; drain until all words are back, then stall at random.
    task automatic test_output_hold();
        int k;
        send_idle_pct = 0;
        stall_pct     = 0;
        settle_pipeline();
        program_frame(16'sh0C00, 16'sh0900, 8'd80, 8'd24);
        hold_left = 80;
        for (k = 0; k < 30; k++) begin
            sample_cell(SCREEN_W'($urandom_range(254)), SCREEN_W'($urandom_range(254)));
        end
        settle_pipeline();
        stall_pct = 50;
        for (k = 0; k < 20; k++) begin
            sample_cell(SCREEN_W'($urandom_range(254)), SCREEN_W'($urandom_range(254)));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_frame_extremes();
        test_random_frames(0, 0, 200);
        test_random_frames(74, 0, 200);
        test_random_frames(0, 74, 200);
        test_random_frames(34, 34, 200);
        test_output_hold();
        settle_pipeline();
        if (fault_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Give up well past the slowest correct run.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[rotozoom_texel_sampler_core.f]
design/rtz_pkg.sv
design/rtz_ram.sv
design/rotozoom_texel_sampler_core.sv
tb/rotozoom_texel_sampler_core_tb.sv
